// ===== rtl/assert_macros.svh =====
// Assertion macros used by the controller of the hue class learner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define HNC_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define HNC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/hnc_pkg.sv =====
// Package of the hue class learner: sizes, operation codes, state and control types.
package hnc_pkg;

   localparam int SLOTS      = 8;
   localparam int GROUP_SIZE = 10;
   localparam int MID        = GROUP_SIZE / 2;

   localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W      = $clog2(GROUP_SIZE);
   localparam int RANK_W     = $clog2(GROUP_SIZE + 1);

   localparam logic [8:0] HUE_CIRCLE      = 9'd360;
   localparam logic [8:0] HUE_HALF        = 9'd180;
   localparam logic [7:0] THRESHOLD_RESET = 8'd20;

   localparam logic [1:0] FUNC_IDENTIFY = 2'd0;
   localparam logic [1:0] FUNC_LEARN    = 2'd1;
   localparam logic [1:0] FUNC_CLEAR    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SORT_GROUP,
      ST_SORT_MED,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic accept;
      logic scan_step;
      logic store_sample;
      logic sort_step;
      logic sel_medians;
      logic store_group;
      logic commit_slot;
      logic clear;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       slot_ok;
      logic       sample_last;
      logic       group_last;
      logic       scan_last;
      logic       sort_last;
      logic       rsp_busy;
   } status_type;

   // Distance between two hues on the circle, never more than half a turn.
   function automatic logic [7:0] circ_dist(input logic [8:0] a, input logic [8:0] b);
      logic [8:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return (d < HUE_HALF) ? d[7:0] : 8'(HUE_CIRCLE - d);
   endfunction

endpackage

// ===== rtl/hnc_if.sv =====
// Request and response channel interfaces of the hue class learner.
interface hnc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [8:0] hue;
   logic [2:0] color_slot;

   modport source (output valid, output func, output hue, output color_slot, input ready);
   modport sink (input valid, input func, input hue, input color_slot, output ready);
endinterface

interface hnc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] color_class;
   logic [7:0] hue_distance;
   logic       learn_done;

   modport source (output valid, output color_class, output hue_distance,
                   output learn_done, input ready);
   modport sink (input valid, input color_class, input hue_distance,
                 input learn_done, output ready);
endinterface

// ===== rtl/hnc_dp.sv =====
// Datapath of the hue class learner: hue table, sample buffers, rank selector, result word.
module hnc_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  hnc_pkg::cmd_type     cmd,
   output hnc_pkg::status_type  status,
   input  logic [1:0]           in_func,
   input  logic [8:0]           in_hue,
   input  logic [2:0]           in_slot,
   input  logic                 csr_wr_en,
   input  logic [7:0]           csr_wr_data,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [3:0]           color_class,
   output logic [7:0]           hue_distance,
   output logic                 learn_done
);

   logic [1:0] func_ff;
   logic [8:0] hue_ff;
   logic [2:0] slot_ff;
   logic [7:0] threshold_ff;

   logic [8:0]                     learned_hue_ff [hnc_pkg::SLOTS];
   logic [hnc_pkg::SLOTS-1:0]      slot_valid_ff;
   logic [8:0]                     samples_ff [hnc_pkg::GROUP_SIZE];
   logic [8:0]                     medians_ff [hnc_pkg::GROUP_SIZE];
   logic [hnc_pkg::CNT_W-1:0]      sample_cnt_ff;
   logic [hnc_pkg::CNT_W-1:0]      group_cnt_ff;

   logic [hnc_pkg::SLOT_IDX_W-1:0] scan_idx_ff;
   logic                           found_ff;
   logic [hnc_pkg::SLOT_IDX_W-1:0] best_idx_ff;
   logic [7:0]                     best_dist_ff;

   logic [hnc_pkg::CNT_W-1:0]      sort_idx_ff;
   logic [8:0]                     median_ff;
   logic                           done_ff;

   logic       rsp_valid_ff;
   logic [3:0] class_ff;
   logic [7:0] dist_ff;
   logic       learn_done_ff;

   logic [8:0]                     in_hue_wrapped;
   logic [hnc_pkg::SLOT_IDX_W-1:0] slot_idx;
   logic [8:0]                     scan_hue;
   logic [7:0]                     scan_dist;
   logic                           scan_better;
   logic [8:0]                     sort_vals [hnc_pkg::GROUP_SIZE];
   logic [8:0]                     cand;
   logic [hnc_pkg::RANK_W-1:0]     lt_cnt;
   logic [hnc_pkg::RANK_W-1:0]     eq_cnt;
   logic                           hit;
   logic [8:0]                     median_now;
   logic                           ident_found;

   assign in_hue_wrapped = (in_hue >= hnc_pkg::HUE_CIRCLE) ? (in_hue - hnc_pkg::HUE_CIRCLE)
                                                            : in_hue;
   assign slot_idx = hnc_pkg::SLOT_IDX_W'(slot_ff);

   assign scan_hue    = learned_hue_ff[scan_idx_ff];
   assign scan_dist   = hnc_pkg::circ_dist(scan_hue, hue_ff);
   assign scan_better = slot_valid_ff[scan_idx_ff] && (!found_ff || (scan_dist < best_dist_ff));

   // The candidate holds the middle rank when fewer than MID+1 values lie below it
   // and the values below plus its equals reach past MID.
   always_comb begin
      lt_cnt = '0;
      eq_cnt = '0;
      for (int k = 0; k < hnc_pkg::GROUP_SIZE; k++) begin
         sort_vals[k] = cmd.sel_medians ? medians_ff[k] : samples_ff[k];
      end
      cand = sort_vals[sort_idx_ff];
      for (int k = 0; k < hnc_pkg::GROUP_SIZE; k++) begin
         lt_cnt = lt_cnt + hnc_pkg::RANK_W'(sort_vals[k] < cand);
         eq_cnt = eq_cnt + hnc_pkg::RANK_W'(sort_vals[k] == cand);
      end
   end

   assign hit = (lt_cnt <= hnc_pkg::RANK_W'(hnc_pkg::MID)) &&
                ((lt_cnt + eq_cnt) > hnc_pkg::RANK_W'(hnc_pkg::MID));
   assign median_now = hit ? cand : median_ff;

   assign ident_found = (func_ff == hnc_pkg::FUNC_IDENTIFY) && found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= hnc_pkg::THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= in_func;
         hue_ff  <= in_hue_wrapped;
         slot_ff <= in_slot;
      end
      if (cmd.scan_step && scan_better) begin
         best_idx_ff  <= scan_idx_ff;
         best_dist_ff <= scan_dist;
      end
      if (cmd.store_sample) begin
         samples_ff[sample_cnt_ff] <= hue_ff;
      end
      if (cmd.sort_step && hit) begin
         median_ff <= cand;
      end
      if (cmd.store_group) begin
         medians_ff[group_cnt_ff] <= median_now;
      end
      if (cmd.commit_slot) begin
         learned_hue_ff[slot_idx] <= median_now;
      end
      if (cmd.load_rsp) begin
         class_ff <= (ident_found && (best_dist_ff <= threshold_ff))
                     ? (4'(best_idx_ff) + 4'd1) : 4'd0;
         dist_ff       <= ident_found ? best_dist_ff : 8'd0;
         learn_done_ff <= done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         sample_cnt_ff <= '0;
         group_cnt_ff  <= '0;
         scan_idx_ff   <= '0;
         found_ff      <= 1'b0;
         sort_idx_ff   <= '0;
         done_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.accept) begin
            scan_idx_ff <= '0;
            found_ff    <= 1'b0;
            sort_idx_ff <= '0;
            done_ff     <= 1'b0;
         end
         if (cmd.scan_step) begin
            scan_idx_ff <= hnc_pkg::SLOT_IDX_W'(scan_idx_ff + 1'b1);
            if (scan_better) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.store_sample) begin
            sample_cnt_ff <= status.sample_last ? '0 : (sample_cnt_ff + 1'b1);
         end
         if (cmd.sort_step) begin
            sort_idx_ff <= status.sort_last ? '0 : (sort_idx_ff + 1'b1);
         end
         if (cmd.store_group) begin
            group_cnt_ff <= status.group_last ? '0 : (group_cnt_ff + 1'b1);
         end
         if (cmd.commit_slot) begin
            slot_valid_ff[slot_idx] <= 1'b1;
            done_ff                 <= 1'b1;
         end
         if (cmd.clear) begin
            slot_valid_ff <= '0;
            sample_cnt_ff <= '0;
            group_cnt_ff  <= '0;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.func        = func_ff;
   assign status.slot_ok     = (32'(slot_ff) < hnc_pkg::SLOTS);
   assign status.sample_last = (sample_cnt_ff == hnc_pkg::CNT_W'(hnc_pkg::GROUP_SIZE - 1));
   assign status.group_last  = (group_cnt_ff == hnc_pkg::CNT_W'(hnc_pkg::GROUP_SIZE - 1));
   assign status.scan_last   = (scan_idx_ff == hnc_pkg::SLOT_IDX_W'(hnc_pkg::SLOTS - 1));
   assign status.sort_last   = (sort_idx_ff == hnc_pkg::CNT_W'(hnc_pkg::GROUP_SIZE - 1));
   assign status.rsp_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign color_class  = class_ff;
   assign hue_distance = dist_ff;
   assign learn_done   = learn_done_ff;

endmodule

// ===== rtl/hnc_ctrl.sv =====
// Controller of the hue class learner: sequences table scan, median passes and reply.
`include "assert_macros.svh"

module hnc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  hnc_pkg::status_type  status,
   output hnc_pkg::cmd_type     cmd
);

   hnc_pkg::state_type state_ff;
   hnc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hnc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hnc_pkg::ST_IDLE: begin
            if (req_valid) state_in = hnc_pkg::ST_DISPATCH;
         end
         hnc_pkg::ST_DISPATCH: begin
            case (status.func)
               hnc_pkg::FUNC_IDENTIFY: state_in = hnc_pkg::ST_SCAN;
               hnc_pkg::FUNC_LEARN: begin
                  state_in = (status.slot_ok && status.sample_last) ? hnc_pkg::ST_SORT_GROUP
                                                                    : hnc_pkg::ST_REPLY;
               end
               default: state_in = hnc_pkg::ST_REPLY;
            endcase
         end
         hnc_pkg::ST_SCAN: begin
            if (status.scan_last) state_in = hnc_pkg::ST_REPLY;
         end
         hnc_pkg::ST_SORT_GROUP: begin
            if (status.sort_last) begin
               state_in = status.group_last ? hnc_pkg::ST_SORT_MED : hnc_pkg::ST_REPLY;
            end
         end
         hnc_pkg::ST_SORT_MED: begin
            if (status.sort_last) state_in = hnc_pkg::ST_REPLY;
         end
         hnc_pkg::ST_REPLY: begin
            if (!status.rsp_busy) state_in = hnc_pkg::ST_IDLE;
         end
         default: state_in = hnc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         hnc_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         hnc_pkg::ST_DISPATCH: begin
            cmd.store_sample = (status.func == hnc_pkg::FUNC_LEARN) && status.slot_ok;
            cmd.clear        = (status.func == hnc_pkg::FUNC_CLEAR);
         end
         hnc_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         hnc_pkg::ST_SORT_GROUP: begin
            cmd.sort_step   = 1'b1;
            cmd.store_group = status.sort_last;
         end
         hnc_pkg::ST_SORT_MED: begin
            cmd.sort_step   = 1'b1;
            cmd.sel_medians = 1'b1;
            cmd.commit_slot = status.sort_last;
         end
         hnc_pkg::ST_REPLY: begin
            cmd.load_rsp = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   `HNC_ASSERT_NEXT(a_accept_dispatch, clock, reset, cmd.accept, state_ff == hnc_pkg::ST_DISPATCH, "accepted word not dispatched")
   `HNC_ASSERT_ALWAYS(a_load_free, clock, reset, !cmd.load_rsp || !status.rsp_busy, "result word overwritten")
   `HNC_ASSERT_ALWAYS(a_commit_slot_ok, clock, reset, !cmd.commit_slot || status.slot_ok, "commit to a slot outside the table")
   `HNC_ASSERT_NEXT(a_group_med, clock, reset, cmd.store_group && status.group_last, state_ff == hnc_pkg::ST_SORT_MED, "last group not followed by median pass")

endmodule

// ===== rtl/hue_nearest_class_learner.sv =====
// Identify: dispatch, a scan of every slot, reply; next word is taken only back in idle.
// Learn: each sample is stored in dispatch; a group end adds a rank selection over the group,
// and the session end one over the medians (one candidate per cycle through the selector).
// Clear, unused codes: dispatch, then reply. A waiting result word holds the next reply back.
// Synchronous reset empties the table, restarts learning and sets the threshold to 20.
module hue_nearest_class_learner (
   input  logic        clock,
   input  logic        reset,
   hnc_req_if.sink     req_chan,
   hnc_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   hnc_pkg::cmd_type    cmd;
   hnc_pkg::status_type status;

   hnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hnc_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_func      (req_chan.func),
      .in_hue       (req_chan.hue),
      .in_slot      (req_chan.color_slot),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .color_class  (rsp_chan.color_class),
      .hue_distance (rsp_chan.hue_distance),
      .learn_done   (rsp_chan.learn_done)
   );

endmodule
